/* rtl/touch_two_point_calibration_defines.svh */
// Assertion macros for the touch calibration block.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef TOUCH_TWO_POINT_CALIBRATION_DEFINES_SVH
`define TOUCH_TWO_POINT_CALIBRATION_DEFINES_SVH
`ifndef SYNTHESIS
`define TTPC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define TTPC_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`else
`define TTPC_ASSERT(label, prop, msg)
`define TTPC_ASSERT_IMPLY(label, ante, cons, msg)
`endif
`endif

/* rtl/ttpc_pkg.sv */
// Shared types and constants for the touch calibration block.
// No dependencies; used by ttpc_axis and touch_two_point_calibration.
package ttpc_pkg;

   localparam int RAW_W       = 12;
   localparam int EVENT_W     = 8;
   localparam int EDGE_MARGIN = 20;
   localparam int DIFF_W      = RAW_W + 1;
   localparam int PROD_W      = 2 * DIFF_W;
   localparam int QUOT_W      = 24;
   localparam int DIV_STEPS   = QUOT_W;
   // input register, multiply, magnitude, divider steps, output stage
   localparam int LATENCY     = DIV_STEPS + 4;

   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAL_X_FIRST   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAL_Y_FIRST   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAL_X_SECOND  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAL_Y_SECOND  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_WIDTH  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_HEIGHT = 3'd5;

   localparam logic [RAW_W-1:0] SCREEN_SIZE_RESET = 12'd40;

   typedef struct packed {
      logic [RAW_W-1:0]   raw_x;
      logic [RAW_W-1:0]   raw_y;
      logic [EVENT_W-1:0] touch_event;
   } req_type;

   typedef struct packed {
      logic [RAW_W-1:0]   pixel_x;
      logic [RAW_W-1:0]   pixel_y;
      logic [EVENT_W-1:0] event_out;
      logic               cal_error;
   } rsp_type;

endpackage

/* rtl/ttpc_axis.sv */
// One axis of the calibration datapath: difference, multiply by span,
// bit-per-stage restoring divide, offset and clamp. Uses ttpc_pkg.
module ttpc_axis (
   input  logic                        clock,
   input  logic                        adv,
   input  logic [ttpc_pkg::RAW_W-1:0]  raw,
   input  logic [ttpc_pkg::RAW_W-1:0]  first,
   input  logic [ttpc_pkg::RAW_W-1:0]  second,
   input  logic [ttpc_pkg::RAW_W-1:0]  size,
   output logic [ttpc_pkg::RAW_W-1:0]  pixel,
   output logic                        bad
);

   localparam int RW = ttpc_pkg::RAW_W;
   localparam int DW = ttpc_pkg::DIFF_W;
   localparam int PW = ttpc_pkg::PROD_W;
   localparam int QW = ttpc_pkg::QUOT_W;
   localparam int NS = ttpc_pkg::DIV_STEPS;

   // calibration values must stay static while items are in flight; the block does not enforce this
   logic signed [DW-1:0] span;
   logic signed [DW-1:0] den;
   logic [RW-1:0]        den_abs;
   logic                 den_zero;

   assign span     = $signed({1'b0, size}) - DW'(2 * ttpc_pkg::EDGE_MARGIN);
   assign den      = $signed({1'b0, second}) - $signed({1'b0, first});
   assign den_abs  = den[DW-1] ? RW'(-den) : den[RW-1:0];
   assign den_zero = (first == second);

   // stage 1: raw difference
   logic signed [DW-1:0] diff_ff;
   // stage 2: product
   logic signed [PW-1:0] prod_ff;
   logic signed [PW-1:0] prod_in;
   // stage 3: magnitude and result sign
   logic [QW-1:0]        mag_ff;
   logic                 neg_ff;
   logic signed [PW-1:0] prod_abs;

   assign prod_in  = diff_ff * span;
   assign prod_abs = prod_ff[PW-1] ? -prod_ff : prod_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         diff_ff <= $signed({1'b0, raw}) - $signed({1'b0, first});
         prod_ff <= prod_in;
         mag_ff  <= prod_abs[QW-1:0];
         neg_ff  <= prod_ff[PW-1] ^ den[DW-1];
      end
   end

   // divider: each stage retires one quotient bit; numerator bits shift out
   // the top of nq while quotient bits shift in at the bottom
   logic [RW-1:0] rem_ff [NS];
   logic [QW-1:0] nq_ff  [NS];
   logic          sgn_ff [NS];

   genvar k;
   generate
      for (k = 0; k < NS; k++) begin : g_step
         logic [RW-1:0] rem_src;
         logic [QW-1:0] nq_src;
         logic          sgn_src;
         logic [RW:0]   trial;
         logic          fits;

         if (k == 0) begin : g_first
            assign rem_src = '0;
            assign nq_src  = mag_ff;
            assign sgn_src = neg_ff;
         end else begin : g_next
            assign rem_src = rem_ff[k-1];
            assign nq_src  = nq_ff[k-1];
            assign sgn_src = sgn_ff[k-1];
         end

         assign trial = {rem_src, nq_src[QW-1]};
         assign fits  = (trial >= {1'b0, den_abs});

         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[k] <= fits ? RW'(trial - {1'b0, den_abs}) : trial[RW-1:0];
               nq_ff[k]  <= {nq_src[QW-2:0], fits};
               sgn_ff[k] <= sgn_src;
            end
         end
      end
   endgenerate

   // output stage: sign, offset, clamp to 0..size
   logic signed [PW-1:0] quot;
   logic signed [PW-1:0] offs;
   logic [RW-1:0]        pixel_ff;
   logic [RW-1:0]        pixel_in;
   logic                 bad_ff;

   always_comb begin
      if (den_zero) begin
         quot = '0;
      end else if (sgn_ff[NS-1]) begin
         quot = -$signed({{(PW-QW){1'b0}}, nq_ff[NS-1]});
      end else begin
         quot = $signed({{(PW-QW){1'b0}}, nq_ff[NS-1]});
      end
      offs = quot + PW'(ttpc_pkg::EDGE_MARGIN);
      if (offs < 0) begin
         pixel_in = '0;
      end else if (offs > $signed({{(PW-RW){1'b0}}, size})) begin
         pixel_in = size;
      end else begin
         pixel_in = offs[RW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pixel_ff <= pixel_in;
         bad_ff   <= den_zero;
      end
   end

   assign pixel = pixel_ff;
   assign bad   = bad_ff;

endmodule

/* rtl/touch_two_point_calibration.sv */
// Two-point touch calibration: maps raw touch samples to clamped pixels.
// Uses ttpc_pkg, ttpc_axis and touch_two_point_calibration_defines.svh.
//
// Usage:
//   req_* carries one raw sample (x, y, event code) per transfer.
//   rsp_* returns the calibrated pixel pair, the event code and cal_error.
//   csr_* writes the calibration points and screen size; write only while
//   no sample is in flight.
// The pipeline is 28 register stages deep: one input register, one multiply
// stage, one magnitude stage, 24 divider stages that each retire one quotient
// bit, and one offset/clamp output stage. The transfer edge loads the first
// stage, and rsp_valid rises once the sample has reached the output stage.
// Throughput is one sample per cycle while the receiver does not stall;
// the divider is fully pipelined.
// When the receiver stalls, the whole pipeline holds and req_ready drops
// in the same cycle; nothing is lost or repeated.
// Reset clears all pipeline valid bits and loads the register reset values
// (points 0, screen sizes 40); there is no clearing pass.
`include "touch_two_point_calibration_defines.svh"

module touch_two_point_calibration (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  ttpc_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output ttpc_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_wr_en,
   input  logic [ttpc_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [ttpc_pkg::RAW_W-1:0]             csr_wdata
);

   localparam int LAT = ttpc_pkg::LATENCY;
   localparam int RW  = ttpc_pkg::RAW_W;

   logic [RW-1:0] cal_x_first_ff;
   logic [RW-1:0] cal_y_first_ff;
   logic [RW-1:0] cal_x_second_ff;
   logic [RW-1:0] cal_y_second_ff;
   logic [RW-1:0] screen_width_ff;
   logic [RW-1:0] screen_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_x_first_ff   <= '0;
         cal_y_first_ff   <= '0;
         cal_x_second_ff  <= '0;
         cal_y_second_ff  <= '0;
         screen_width_ff  <= ttpc_pkg::SCREEN_SIZE_RESET;
         screen_height_ff <= ttpc_pkg::SCREEN_SIZE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            ttpc_pkg::CSR_CAL_X_FIRST:   cal_x_first_ff   <= csr_wdata;
            ttpc_pkg::CSR_CAL_Y_FIRST:   cal_y_first_ff   <= csr_wdata;
            ttpc_pkg::CSR_CAL_X_SECOND:  cal_x_second_ff  <= csr_wdata;
            ttpc_pkg::CSR_CAL_Y_SECOND:  cal_y_second_ff  <= csr_wdata;
            ttpc_pkg::CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_wdata;
            ttpc_pkg::CSR_SCREEN_HEIGHT: screen_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // advance the whole pipeline unless the output stage is held
   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   logic                         vld_ff [LAT];
   logic [ttpc_pkg::EVENT_W-1:0] event_ff [LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         event_ff[0] <= req_data.touch_event;
         for (int i = 1; i < LAT; i++) begin
            event_ff[i] <= event_ff[i-1];
         end
      end
   end

   logic [RW-1:0] pixel_x;
   logic [RW-1:0] pixel_y;
   logic          bad_x;
   logic          bad_y;

   ttpc_axis u_axis_x (
      .clock  (clock),
      .adv    (adv),
      .raw    (req_data.raw_x),
      .first  (cal_x_first_ff),
      .second (cal_x_second_ff),
      .size   (screen_width_ff),
      .pixel  (pixel_x),
      .bad    (bad_x)
   );

   ttpc_axis u_axis_y (
      .clock  (clock),
      .adv    (adv),
      .raw    (req_data.raw_y),
      .first  (cal_y_first_ff),
      .second (cal_y_second_ff),
      .size   (screen_height_ff),
      .pixel  (pixel_y),
      .bad    (bad_y)
   );

   assign rsp_valid          = vld_ff[LAT-1];
   assign rsp_data.pixel_x   = pixel_x;
   assign rsp_data.pixel_y   = pixel_y;
   assign rsp_data.event_out = event_ff[LAT-1];
   assign rsp_data.cal_error = bad_x || bad_y;

   logic [RW-1:0] margin_x;
   logic          x_pts_equal;
   logic          y_pts_equal;
   logic          pts_equal;
   logic          x_deg_rsp;
   assign margin_x = (screen_width_ff < RW'(ttpc_pkg::EDGE_MARGIN)) ?
                     screen_width_ff : RW'(ttpc_pkg::EDGE_MARGIN);
   assign x_pts_equal = (cal_x_first_ff == cal_x_second_ff);
   assign y_pts_equal = (cal_y_first_ff == cal_y_second_ff);
   assign pts_equal   = x_pts_equal || y_pts_equal;
   assign x_deg_rsp   = rsp_valid && x_pts_equal;

   `TTPC_ASSERT_IMPLY(a_clamp_x, rsp_valid, rsp_data.pixel_x <= screen_width_ff, "x over width")
   `TTPC_ASSERT_IMPLY(a_clamp_y, rsp_valid, rsp_data.pixel_y <= screen_height_ff, "y over height")
   `TTPC_ASSERT_IMPLY(a_error_flag, rsp_valid, rsp_data.cal_error == pts_equal, "cal_error wrong")
   `TTPC_ASSERT_IMPLY(a_x_margin, x_deg_rsp, rsp_data.pixel_x == margin_x, "x off margin")
   `TTPC_ASSERT(a_ready_on_stall, (rsp_valid && !rsp_ready) == !req_ready, "req_ready wrong")

endmodule
